// ===== rtl/core/angle_frame_crc_filter_unwrap_defines.svh =====
// assertion helpers for the angle frame block
`ifndef ANGLE_FRAME_CRC_FILTER_UNWRAP_DEFINES_SVH
`define ANGLE_FRAME_CRC_FILTER_UNWRAP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define AFCU_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);
`define AFCU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define AFCU_ASSERT_ALWAYS(lbl, expr, msg)
`define AFCU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/core/afcu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package afcu_pkg;

    localparam int CRC_W   = 6;
    localparam int FRAME_W = 24;
    localparam int PHASE_W = 24;
    localparam int Q_DEPTH = 2;
    localparam int Q_CNT_W = 2;
    localparam int STEP_W  = 5;
    localparam int CV_W    = 34;
    localparam int CZ_W    = 27;
    localparam int ACC_W   = 36;

    localparam logic [1:0] CFG_ALPHA  = 2'd0;
    localparam logic [1:0] CFG_THRESH = 2'd1;

    localparam logic signed [CV_W-1:0] ONE_Q30      = 34'sd652032874;
    localparam logic signed [CZ_W-1:0] QUARTER_TURN = 27'sd4194304;
    localparam logic signed [CZ_W-1:0] HALF_TURN    = 27'sd8388608;

    localparam logic [5:0] CRC6_LUT [64] = '{
        6'h00, 6'h03, 6'h06, 6'h05, 6'h0C, 6'h0F, 6'h0A, 6'h09,
        6'h18, 6'h1B, 6'h1E, 6'h1D, 6'h14, 6'h17, 6'h12, 6'h11,
        6'h30, 6'h33, 6'h36, 6'h35, 6'h3C, 6'h3F, 6'h3A, 6'h39,
        6'h28, 6'h2B, 6'h2E, 6'h2D, 6'h24, 6'h27, 6'h22, 6'h21,
        6'h23, 6'h20, 6'h25, 6'h26, 6'h2F, 6'h2C, 6'h29, 6'h2A,
        6'h3B, 6'h38, 6'h3D, 6'h3E, 6'h37, 6'h34, 6'h31, 6'h32,
        6'h13, 6'h10, 6'h15, 6'h16, 6'h1F, 6'h1C, 6'h19, 6'h1A,
        6'h0B, 6'h08, 6'h0D, 6'h0E, 6'h07, 6'h04, 6'h01, 6'h02
    };

    // atan(2^-i) in 2^-24 turn
    localparam logic [22:0] ATAN_LUT [20] = '{
        23'd2097152, 23'd1238021, 23'd654136, 23'd332050, 23'd166669,
        23'd83416, 23'd41718, 23'd20860, 23'd10430, 23'd5215,
        23'd2608, 23'd1304, 23'd652, 23'd326, 23'd163,
        23'd81, 23'd41, 23'd20, 23'd10, 23'd5
    };

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [CRC_W-1:0]   rx;
        logic [CRC_W-1:0]   calc;
        logic               bad;
        logic               clr;
    } afcu_item_t;

    typedef struct packed {
        logic [Q_CNT_W-1:0] count;
        logic               full;
        logic               empty;
    } afcu_qstat_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_ROT,
        B_Q15,
        B_BLEND,
        B_VEC_INIT,
        B_VEC,
        B_FINISH
    } afcu_state_t;

    function automatic logic [CRC_W-1:0] crc6_18(input logic [17:0] d);
        logic [5:0] idx;
        idx = d[17:12];
        idx = d[11:6] ^ CRC6_LUT[idx];
        idx = d[5:0] ^ CRC6_LUT[idx];
        return CRC6_LUT[idx];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/afcu_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module afcu_front import afcu_pkg::*; #(
    parameter int ANGLE_BITS = 14
) (
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,
    input  wire afcu_qstat_t q_stat,
    output logic             push,
    output afcu_item_t       item
);

    logic [FRAME_W-1:0] frame;
    logic [ANGLE_BITS-1:0] raw;

    assign frame    = s_tdata[FRAME_W-1:0];
    assign raw      = frame[FRAME_W-1 -: ANGLE_BITS];
    assign s_tready = !q_stat.full;
    assign push     = s_tvalid && s_tready;

    always_comb begin
        item.phase = PHASE_W'({raw, {(PHASE_W-ANGLE_BITS){1'b0}}});
        item.rx    = frame[CRC_W-1:0];
        item.calc  = crc6_18(frame[23:6]);
        item.bad   = (item.rx != item.calc);
        item.clr   = s_tdata[24];
    end

endmodule
`default_nettype wire

// ===== rtl/core/afcu_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
module afcu_fifo import afcu_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push,
    input  wire afcu_item_t wr_item,
    input  wire logic       pop,
    output afcu_item_t      rd_item,
    output afcu_qstat_t     q_stat
);

    afcu_item_t mem [Q_DEPTH];
    logic wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop) rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop) count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

    assign rd_item      = mem[rd_ptr_reg];
    assign q_stat.count = count_reg;
    assign q_stat.full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign q_stat.empty = (count_reg == '0);

endmodule
`default_nettype wire

// ===== rtl/core/afcu_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module afcu_back import afcu_pkg::*; #(
    parameter int CORDIC_STEPS = 16,
    parameter int TURN_BITS    = 24
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [15:0] alpha,
    input  wire logic [15:0] thresh,
    input  wire afcu_qstat_t q_stat,
    input  wire afcu_item_t  rd_item,
    output logic             pop,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata
);

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);
    localparam logic signed [TURN_BITS-1:0] TMAX = {1'b0, {(TURN_BITS-1){1'b1}}};
    localparam logic signed [TURN_BITS-1:0] TMIN = {1'b1, {(TURN_BITS-1){1'b0}}};

    afcu_state_t state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic signed [CV_W-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [CZ_W-1:0] z_reg, z_next;
    afcu_item_t item_reg, item_next;
    logic signed [15:0] nvx_reg, nvx_next, nvy_reg, nvy_next;
    logic signed [15:0] fx_reg, fx_next, fy_reg, fy_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [1:0] bidx_reg, bidx_next;
    logic zero_reg, zero_next;
    logic [15:0] prev_reg, prev_next;
    logic signed [TURN_BITS-1:0] turn_reg, turn_next;
    logic eflag_reg, eflag_next;
    logic [CRC_W-1:0] erx_reg, erx_next, ecalc_reg, ecalc_next;
    logic m_valid_reg, m_valid_next;
    logic [55:0] m_data_reg, m_data_next;

    // shared cordic step
    logic signed [CV_W-1:0] sx, sy, cx, cy;
    logic signed [CZ_W-1:0] at, cz;
    logic dir_plus;

    always_comb begin
        sx = x_reg >>> step_reg;
        sy = y_reg >>> step_reg;
        at = signed'({{(CZ_W-23){1'b0}}, ATAN_LUT[step_reg]});
        dir_plus = (state_reg == B_ROT) ? !z_reg[CZ_W-1] : y_reg[CV_W-1];
        if (dir_plus) begin
            cx = x_reg - sy;
            cy = y_reg + sx;
            cz = z_reg - at;
        end else begin
            cx = x_reg + sy;
            cy = y_reg - sx;
            cz = z_reg + at;
        end
    end

    function automatic logic signed [15:0] to_q15(input logic signed [CV_W-1:0] v);
        logic signed [CV_W:0] t;
        t = ($signed({v[CV_W-1], v}) + $signed((CV_W+1)'(16384))) >>> 15;
        if (t > $signed((CV_W+1)'(32767))) return 16'sh7FFF;
        else if (t < -$signed((CV_W+1)'(32768))) return 16'sh8000;
        else return t[15:0];
    endfunction

    // blend multiply, one product per cycle
    logic signed [17:0] mul_a;
    logic signed [15:0] mul_b;
    logic signed [ACC_W-1:0] prod, acc_sum, blend_sh;
    logic signed [15:0] blend_sat;

    always_comb begin
        mul_a = bidx_reg[0] ? signed'(18'(17'h10000 - {1'b0, alpha}))
                            : signed'({2'b00, alpha});
        case (bidx_reg)
            2'd0:    mul_b = nvx_reg;
            2'd1:    mul_b = fx_reg;
            2'd2:    mul_b = nvy_reg;
            default: mul_b = fy_reg;
        endcase
        prod     = ACC_W'(34'(mul_a) * 34'(mul_b));
        acc_sum  = (bidx_reg[0] ? acc_reg : $signed(ACC_W'(32768))) + prod;
        blend_sh = acc_sum >>> 16;
        if (blend_sh > $signed(ACC_W'(32767))) blend_sat = 16'sh7FFF;
        else if (blend_sh < -$signed(ACC_W'(32768))) blend_sat = 16'sh8000;
        else blend_sat = blend_sh[15:0];
    end

    // rotation start angle, vectoring start vector and finish values
    logic signed [CZ_W-1:0] z0;
    logic signed [CV_W-1:0] vx0, vy0;
    logic [PHASE_W-1:0] neg_z;
    logic [PHASE_W:0] rnd;
    logic [15:0] ang;
    logic signed [16:0] dlt, adlt;
    logic wrap;
    logic signed [TURN_BITS-1:0] turn_new;
    logic signed [31:0] turn32;
    logic eflag_o;
    logic [CRC_W-1:0] erx_o, ecalc_o;
    logic out_free;

    always_comb begin
        z0    = CZ_W'(signed'(rd_item.phase));
        vx0   = CV_W'(fx_reg) <<< 14;
        vy0   = CV_W'(fy_reg) <<< 14;
        neg_z = PHASE_W'(0) - z_reg[PHASE_W-1:0];
        rnd   = {1'b0, neg_z} + (PHASE_W+1)'(128);
        ang   = zero_reg ? 16'd0 : rnd[23:8];
        dlt   = signed'({1'b0, ang}) - signed'({1'b0, prev_reg});
        adlt  = dlt[16] ? -dlt : dlt;
        wrap  = adlt > signed'({1'b0, thresh});
        turn_new = turn_reg;
        if (wrap && !dlt[16] && turn_reg != TMIN) turn_new = turn_reg - 1'b1;
        if (wrap && dlt[16] && turn_reg != TMAX) turn_new = turn_reg + 1'b1;
        turn32  = 32'(turn_new);
        eflag_o = item_reg.bad ? 1'b1 : eflag_reg;
        erx_o   = item_reg.bad ? item_reg.rx : erx_reg;
        ecalc_o = item_reg.bad ? item_reg.calc : ecalc_reg;
        out_free = !m_valid_reg || m_tready;
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        item_next = item_reg;
        nvx_next = nvx_reg;
        nvy_next = nvy_reg;
        fx_next = fx_reg;
        fy_next = fy_reg;
        acc_next = acc_reg;
        bidx_next = bidx_reg;
        zero_next = zero_reg;
        prev_next = prev_reg;
        turn_next = turn_reg;
        eflag_next = eflag_reg;
        erx_next = erx_reg;
        ecalc_next = ecalc_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next = m_data_reg;
        pop = 1'b0;
        case (state_reg)
            B_IDLE: begin
                if (!q_stat.empty) begin
                    pop = 1'b1;
                    item_next = rd_item;
                    step_next = '0;
                    if (rd_item.bad) begin
                        state_next = B_VEC_INIT;
                    end else begin
                        state_next = B_ROT;
                        if (z0 > QUARTER_TURN) begin
                            x_next = '0;
                            y_next = ONE_Q30;
                            z_next = z0 - QUARTER_TURN;
                        end else if (z0 < -QUARTER_TURN) begin
                            x_next = '0;
                            y_next = -ONE_Q30;
                            z_next = z0 + QUARTER_TURN;
                        end else begin
                            x_next = ONE_Q30;
                            y_next = '0;
                            z_next = z0;
                        end
                    end
                end
            end
            B_ROT, B_VEC: begin
                x_next = cx;
                y_next = cy;
                z_next = cz;
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP) begin
                    state_next = (state_reg == B_ROT) ? B_Q15 : B_FINISH;
                end
            end
            B_Q15: begin
                nvx_next = to_q15(x_reg);
                nvy_next = to_q15(y_reg);
                bidx_next = 2'd0;
                state_next = B_BLEND;
            end
            B_BLEND: begin
                acc_next = acc_sum;
                bidx_next = bidx_reg + 1'b1;
                if (bidx_reg == 2'd1) fx_next = blend_sat;
                if (bidx_reg == 2'd3) begin
                    fy_next = blend_sat;
                    state_next = B_VEC_INIT;
                end
            end
            B_VEC_INIT: begin
                zero_next = (fx_reg == '0) && (fy_reg == '0);
                step_next = '0;
                if (fx_reg[15]) begin
                    x_next = -vx0;
                    y_next = -vy0;
                    z_next = HALF_TURN;
                end else begin
                    x_next = vx0;
                    y_next = vy0;
                    z_next = '0;
                end
                state_next = B_VEC;
            end
            B_FINISH: begin
                if (out_free) begin
                    prev_next = ang;
                    turn_next = turn_new;
                    eflag_next = item_reg.clr ? 1'b0 : eflag_o;
                    erx_next = item_reg.clr ? '0 : erx_o;
                    ecalc_next = item_reg.clr ? '0 : ecalc_o;
                    m_valid_next = 1'b1;
                    m_data_next = {2'b00, ecalc_o, erx_o, eflag_o, item_reg.bad,
                                   turn32[23:0], ang};
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            fx_reg      <= '0;
            fy_reg      <= '0;
            prev_reg    <= '0;
            turn_reg    <= '0;
            eflag_reg   <= 1'b0;
            erx_reg     <= '0;
            ecalc_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fx_reg      <= fx_next;
            fy_reg      <= fy_next;
            prev_reg    <= prev_next;
            turn_reg    <= turn_next;
            eflag_reg   <= eflag_next;
            erx_reg     <= erx_next;
            ecalc_reg   <= ecalc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg   <= step_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        z_reg      <= z_next;
        item_reg   <= item_next;
        nvx_reg    <= nvx_next;
        nvy_reg    <= nvy_next;
        acc_reg    <= acc_next;
        bidx_reg   <= bidx_next;
        zero_reg   <= zero_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
`default_nettype wire

// ===== rtl/core/angle_frame_crc_filter_unwrap.sv =====
// angle frame decoder: crc6 check, vector low-pass filter, atan2 and turn count
// input stream s_*: one sensor frame per transaction, the front checks the crc
// and queues the frame in a two-entry queue, so up to two frames are taken
// while the back is busy.
// config channel cfg_*: index 0 writes alpha, 1 the unwrap threshold; always
// ready, write only while the block is idle.
// output stream m_*: one result per frame, held in an output register until
// taken; a stalled receiver blocks the back, then the queue fills and
// s_tready drops.
// processing: a good frame runs rotation, q15 conversion, blend and then
// vectoring on the one shared iterative cordic unit, a bad frame only
// vectoring of the held filter vector; the back finishes one frame before
// it pops the next, while the queue takes further frames.
// reset (aresetn low, synchronous): filter vector, previous angle, turn count
// and error record are zero, config registers take their default values.
`timescale 1ns / 1ps
`default_nettype none
`include "angle_frame_crc_filter_unwrap_defines.svh"
module angle_frame_crc_filter_unwrap import afcu_pkg::*; #(
    parameter int ANGLE_BITS   = 14,
    parameter int CORDIC_STEPS = 16,
    parameter int TURN_BITS    = 24
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // frame[23:0], clear_error[24], zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // angle[15:0], turns[39:16], crc_bad[40],
                                        // error_latched[41], error_received_crc[47:42],
                                        // error_calculated_crc[53:48], zero
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic [15:0] alpha_reg, thresh_reg;
    afcu_qstat_t q_stat;
    afcu_item_t wr_item, rd_item;
    logic push, pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg  <= 16'd26214;
            thresh_reg <= 16'd52429;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_ALPHA:  alpha_reg  <= cfg_data;
                CFG_THRESH: thresh_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    afcu_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_stat   (q_stat),
        .push     (push),
        .item     (wr_item)
    );

    afcu_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_item (wr_item),
        .pop     (pop),
        .rd_item (rd_item),
        .q_stat  (q_stat)
    );

    afcu_back #(.CORDIC_STEPS(CORDIC_STEPS), .TURN_BITS(TURN_BITS)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .alpha    (alpha_reg),
        .thresh   (thresh_reg),
        .q_stat   (q_stat),
        .rd_item  (rd_item),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    `AFCU_ASSERT_ALWAYS(a_q_bound, q_stat.count <= Q_CNT_W'(Q_DEPTH), "queue count overflow")
    `AFCU_ASSERT_NEXT(a_q_push, s_tvalid && s_tready, q_stat.count != '0, "accepted frame lost")
    `AFCU_ASSERT_ALWAYS(a_err_sticky, !m_tvalid || !m_tdata[40] || m_tdata[41], "bad crc not latched")

endmodule
`default_nettype wire
